FILE: hw/rtl/epsc_pkg.sv
// Shared types, constants, calendar helpers and microcode ROM for the epoch-to-calendar block.
package epsc_pkg;

    localparam int UPC_W = 4;

    localparam logic [5:0] SECS_PER_MIN  = 6'd60;
    localparam logic [5:0] MINS_PER_HOUR = 6'd60;
    localparam logic [5:0] HOURS_PER_DAY = 6'd24;

    // Rounded-up reciprocals of the odd divisor factors: x / 60 is ((x >> 2) * RECIP_15) >> 34
    // and x / 24 is ((x >> 3) * RECIP_3) >> 33, exact over the whole 32-bit range.
    localparam logic [31:0] RECIP_15 = 32'h4444_4445;
    localparam logic [31:0] RECIP_3  = 32'hAAAA_AAAB;

    localparam logic [8:0] LEAP_YEAR_DAYS   = 9'd366;
    localparam logic [8:0] COMMON_YEAR_DAYS = 9'd365;
    localparam logic [4:0] FEB_LEAP_DAYS    = 5'd29;
    localparam logic [4:0] FEB_COMMON_DAYS  = 5'd28;

    // 2100 is the only century year in range that is not a leap year.
    localparam logic [7:0] YEAR_2100_OFF = 8'd130;
    localparam logic [7:0] MAX_YEAR_OFF  = 8'd136;

    // Microcode step numbers.
    localparam logic [UPC_W-1:0] STEP_LOAD     = 4'd0;
    localparam logic [UPC_W-1:0] STEP_SEC_DIV  = 4'd1;
    localparam logic [UPC_W-1:0] STEP_SEC_SAVE = 4'd2;
    localparam logic [UPC_W-1:0] STEP_MIN_DIV  = 4'd3;
    localparam logic [UPC_W-1:0] STEP_MIN_SAVE = 4'd4;
    localparam logic [UPC_W-1:0] STEP_HR_DIV   = 4'd5;
    localparam logic [UPC_W-1:0] STEP_HR_SAVE  = 4'd6;
    localparam logic [UPC_W-1:0] STEP_YEAR     = 4'd7;
    localparam logic [UPC_W-1:0] STEP_MONTH    = 4'd8;
    localparam logic [UPC_W-1:0] STEP_EMIT     = 4'd9;
    localparam logic [UPC_W-1:0] STEP_RETURN   = 4'd10;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV60,
        OP_DIV24,
        OP_SAVE_SEC,
        OP_SAVE_MIN,
        OP_SAVE_HOUR,
        OP_YEAR,
        OP_MONTH,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_YEAR_MORE,
        COND_MONTH_MORE,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [UPC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic no_input;
        logic year_more;
        logic month_more;
        logic out_busy;
    } t_flags;

    // Year offset is from 1970, so a multiple of four lands on offset mod 4 == 2.
    function automatic logic is_leap(input logic [7:0] off);
        return (off[1:0] == 2'b10) && (off != YEAR_2100_OFF);
    endfunction

    function automatic logic [8:0] year_len(input logic [7:0] off);
        return is_leap(off) ? LEAP_YEAR_DAYS : COMMON_YEAR_DAYS;
    endfunction

    // Month index 0 is January.
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        unique case (mon)
            4'd1:    len = leap ? FEB_LEAP_DAYS : FEB_COMMON_DAYS;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic t_uword ucode(input logic [UPC_W-1:0] step);
        t_uword w;
        unique case (step)
            STEP_LOAD:     w = '{OP_LOAD,      COND_NO_INPUT,   STEP_LOAD};
            STEP_SEC_DIV:  w = '{OP_DIV60,     COND_NONE,       STEP_LOAD};
            STEP_SEC_SAVE: w = '{OP_SAVE_SEC,  COND_NONE,       STEP_LOAD};
            STEP_MIN_DIV:  w = '{OP_DIV60,     COND_NONE,       STEP_LOAD};
            STEP_MIN_SAVE: w = '{OP_SAVE_MIN,  COND_NONE,       STEP_LOAD};
            STEP_HR_DIV:   w = '{OP_DIV24,     COND_NONE,       STEP_LOAD};
            STEP_HR_SAVE:  w = '{OP_SAVE_HOUR, COND_NONE,       STEP_LOAD};
            STEP_YEAR:     w = '{OP_YEAR,      COND_YEAR_MORE,  STEP_YEAR};
            STEP_MONTH:    w = '{OP_MONTH,     COND_MONTH_MORE, STEP_MONTH};
            STEP_EMIT:     w = '{OP_EMIT,      COND_OUT_BUSY,   STEP_EMIT};
            STEP_RETURN:   w = '{OP_NOP,       COND_ALWAYS,     STEP_LOAD};
            default:       w = '{OP_NOP,       COND_ALWAYS,     STEP_LOAD};
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/epsc_sequencer.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module epsc_sequencer
    import epsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_flags           i_flags,
    output t_uword           o_uword,
    output logic [UPC_W-1:0] o_step
);

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_uword           w_uword;
    logic             w_take;

    assign w_uword = ucode(r_upc);

    always_comb begin
        unique case (w_uword.cond)
            COND_NONE:       w_take = 1'b0;
            COND_ALWAYS:     w_take = 1'b1;
            COND_NO_INPUT:   w_take = i_flags.no_input;
            COND_YEAR_MORE:  w_take = i_flags.year_more;
            COND_MONTH_MORE: w_take = i_flags.month_more;
            COND_OUT_BUSY:   w_take = i_flags.out_busy;
            default:         w_take = 1'b1;
        endcase
        n_upc = w_take ? w_uword.target : r_upc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= STEP_LOAD;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_uword = w_uword;
    assign o_step  = r_upc;

endmodule

FILE: hw/rtl/epoch_seconds_to_calendar.sv
// Top level: epoch seconds to calendar date and time of day, microcoded datapath.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_epoch_seconds[31:0]
//  out     | output    | o_out_valid / i_out_ready | second, minute, hour, year, month, day
//
// Each word passes from acceptance to o_out_valid through three divisions by reciprocal
// multiplication, each followed by a save step that forms the remainder, a year loop and
// a month loop that step whole years and months off the day count, each with a last pass
// to leave it, and the emit step. The year offset runs 0..136 and the month index 0..11.
// The worst case is December of year offset 135, set by the one-year-per-cycle loop.
// After the emit step the sequencer passes its return step to the load step, which raises o_in_ready.
// Reset (synchronous, active low) returns the sequencer to its load step and clears
// o_out_valid. The output register parts the two sides; a stalled result holds the
// sequencer at its emit step only while a new result is ready and the old is not taken.
module epoch_seconds_to_calendar
    import epsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_second_of_minute,
    output logic [5:0]  o_minute_of_hour,
    output logic [4:0]  o_hour_of_day,
    output logic [7:0]  o_year_offset,
    output logic [3:0]  o_month_number,
    output logic [4:0]  o_day_of_month
);

    t_uword           w_uword;
    t_flags           w_flags;
    logic [UPC_W-1:0] w_step;

    // Datapath registers.
    logic [31:0]      r_quo;      // dividend, replaced by the quotient on a divide step
    logic [5:0]       r_rem;      // low bits of the last dividend, for the remainder
    logic [5:0]       r_sec;
    logic [5:0]       r_min;
    logic [4:0]       r_hour;
    logic [15:0]      r_days;     // whole days, then day of year, then day of month
    logic [7:0]       r_year;
    logic [3:0]       r_mon;
    logic             r_out_valid;

    logic             w_div24;
    logic [29:0]      w_mul_n;
    logic [31:0]      w_mul_k;
    logic [61:0]      w_prod;
    logic [31:0]      w_div_quo;
    logic [5:0]       w_divisor;
    logic [5:0]       w_qd;
    logic [5:0]       w_div_rem;
    logic [8:0]       w_ylen;
    logic [4:0]       w_mlen;
    logic             w_year_more;
    logic             w_month_more;
    logic             w_out_busy;
    logic             w_emit;

    epsc_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uword (w_uword),
        .o_step  (w_step)
    );

    // Divide by a constant: drop the power-of-two factor of the divisor, multiply by the
    // rounded-up reciprocal of the odd factor and keep the top bits of the product.
    assign w_div24   = (w_uword.op == OP_DIV24);
    assign w_mul_n   = w_div24 ? {1'b0, r_quo[31:3]} : r_quo[31:2];
    assign w_mul_k   = w_div24 ? RECIP_3 : RECIP_15;
    assign w_prod    = {32'd0, w_mul_n} * {30'd0, w_mul_k};
    assign w_div_quo = w_div24 ? {3'd0, w_prod[61:33]} : {4'd0, w_prod[61:34]};

    // The remainder is below 64, so the low six bits of dividend minus quotient times
    // divisor give it exactly; form it on the save step after each divide.
    assign w_divisor = (w_uword.op == OP_SAVE_HOUR) ? HOURS_PER_DAY : SECS_PER_MIN;
    assign w_qd      = r_quo[5:0] * w_divisor;
    assign w_div_rem = r_rem - w_qd;

    assign w_ylen       = year_len(r_year);
    assign w_mlen       = month_len(r_mon, is_leap(r_year));
    assign w_year_more  = (r_days >= {7'd0, w_ylen});
    assign w_month_more = (r_days >= {11'd0, w_mlen});
    assign w_out_busy   = r_out_valid && !i_out_ready;
    assign w_emit       = (w_uword.op == OP_EMIT) && !w_out_busy;

    assign w_flags = '{
        no_input:   !i_in_valid,
        year_more:  w_year_more,
        month_more: w_month_more,
        out_busy:   w_out_busy
    };

    always_ff @(posedge i_clk) begin
        unique case (w_uword.op)
            OP_LOAD: begin
                r_quo <= i_epoch_seconds;
            end
            OP_DIV60, OP_DIV24: begin
                r_quo <= w_div_quo;
                r_rem <= r_quo[5:0];
            end
            OP_SAVE_SEC: begin
                r_sec <= w_div_rem;
            end
            OP_SAVE_MIN: begin
                r_min <= w_div_rem;
            end
            OP_SAVE_HOUR: begin
                // At most 49710 days remain, so the low half holds the day count.
                r_hour <= w_div_rem[4:0];
                r_days <= r_quo[15:0];
                r_year <= '0;
                r_mon  <= '0;
            end
            OP_YEAR: begin
                if (w_year_more) begin
                    r_days <= r_days - {7'd0, w_ylen};
                    r_year <= r_year + 1'b1;
                end
            end
            OP_MONTH: begin
                if (w_month_more) begin
                    r_days <= r_days - {11'd0, w_mlen};
                    r_mon  <= r_mon + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: load on emit, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_second_of_minute <= r_sec;
            o_minute_of_hour   <= r_min;
            o_hour_of_day      <= r_hour;
            o_year_offset      <= r_year;
            o_month_number     <= r_mon + 1'b1;
            o_day_of_month     <= r_days[4:0] + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_in_ready  = (w_step == STEP_LOAD);

    // An accepted word always starts the seconds division next.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (w_step == STEP_SEC_DIV))
        else $error("accepted word did not start the division");

    // A new result appears only from the emit step.
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> ($past(w_step) == STEP_EMIT))
        else $error("result raised outside the emit step");

    // The year loop never steps past the end of the 32-bit range.
    a_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step == STEP_MONTH) |-> (r_year <= MAX_YEAR_OFF))
        else $error("year offset out of range");

    // The delivered day fits the delivered month.
    a_day_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_day_of_month != 5'd0) &&
            (o_day_of_month <= month_len(o_month_number - 1'b1, is_leap(o_year_offset))))
        else $error("day of month exceeds month length");

endmodule
